FILE: hw/rtl/wac_pkg.sv
// Shared types, constants and helpers for the weighted ancestor climb block.
package wac_pkg;

  localparam int MAX_NODES = 1024;
  localparam int LEVELS    = 10;

  localparam int NODE_W  = 10;
  localparam int DIST_W  = 32;
  localparam int BUDG_W  = 31;
  localparam int OP_W    = 2;
  localparam int CNT_CFG_W = 11;

  localparam int IDX_W   = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
  localparam int LVL_W   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int LEFT_W  = 38;
  localparam int COST_W  = DIST_W + 1;

  localparam int DT_DEPTH = 1 << IDX_W;
  localparam int JT_DEPTH = LEVELS * (1 << IDX_W);
  localparam int JT_AW    = $clog2(JT_DEPTH);

  localparam logic [CNT_CFG_W-1:0] NODE_COUNT_RST = CNT_CFG_W'(1024);

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   opcode;
    logic [NODE_W-1:0] node_id;
    logic [NODE_W-1:0] parent_id;
    logic [DIST_W-1:0] root_distance;
    logic [BUDG_W-1:0] budget;
  } wac_req_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor_id;
    logic [OP_W-1:0]   done_kind;
  } wac_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_B_RDA,
    ST_B_RDB,
    ST_B_WR,
    ST_Q_LOAD,
    ST_Q_UP,
    ST_Q_CMP
  } wac_state_t;

  typedef struct packed {
    logic latch;
    logic ld_write;
    logic b_init;
    logic b_rd_a;
    logic b_rd_b;
    logic b_wr;
    logic q_init;
    logic q_load;
    logic q_up;
    logic q_cmp;
    logic finish;
  } wac_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic node_oor;
    logic b_skip;
    logic idx_last;
    logic lvl_top;
    logic lvl_zero;
  } wac_stat_t;

  function automatic logic [IDX_W-1:0] clamp_idx(input logic [IDX_W-1:0] v);
    return (32'(v) >= 32'(MAX_NODES)) ? '0 : v;
  endfunction

endpackage

FILE: hw/rtl/wac_ram.sv
// Generic single write port, single read port RAM with registered read data.
module wac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/wac_ctrl.sv
// Controller state machine sequencing load, build and query requests.
module wac_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  wac_pkg::wac_stat_t stat,
  output wac_pkg::wac_cmd_t  cmd
);

  wac_pkg::wac_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wac_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt = wac_pkg::ST_DISPATCH;
        end
      end
      wac_pkg::ST_DISPATCH: begin
        priority case (stat.op)
          wac_pkg::OP_BUILD: state_nxt = stat.b_skip ? wac_pkg::ST_IDLE : wac_pkg::ST_B_RDA;
          wac_pkg::OP_QUERY: state_nxt = stat.node_oor ? wac_pkg::ST_IDLE : wac_pkg::ST_Q_LOAD;
          default:           state_nxt = wac_pkg::ST_IDLE;
        endcase
      end
      wac_pkg::ST_B_RDA: state_nxt = wac_pkg::ST_B_RDB;
      wac_pkg::ST_B_RDB: state_nxt = wac_pkg::ST_B_WR;
      wac_pkg::ST_B_WR: begin
        state_nxt = (stat.idx_last && stat.lvl_top) ? wac_pkg::ST_IDLE : wac_pkg::ST_B_RDA;
      end
      wac_pkg::ST_Q_LOAD: state_nxt = wac_pkg::ST_Q_UP;
      wac_pkg::ST_Q_UP:   state_nxt = wac_pkg::ST_Q_CMP;
      wac_pkg::ST_Q_CMP: begin
        state_nxt = stat.lvl_zero ? wac_pkg::ST_IDLE : wac_pkg::ST_Q_UP;
      end
      default: state_nxt = wac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      wac_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      wac_pkg::ST_DISPATCH: begin
        priority case (stat.op)
          wac_pkg::OP_LOAD: begin
            cmd.ld_write = 1'b1;
            cmd.finish   = 1'b1;
          end
          wac_pkg::OP_BUILD: begin
            cmd.b_init = 1'b1;
            cmd.finish = stat.b_skip;
          end
          wac_pkg::OP_QUERY: begin
            cmd.q_init = 1'b1;
            cmd.finish = stat.node_oor;
          end
          default: cmd = '0;
        endcase
      end
      wac_pkg::ST_B_RDA: cmd.b_rd_a = 1'b1;
      wac_pkg::ST_B_RDB: cmd.b_rd_b = 1'b1;
      wac_pkg::ST_B_WR: begin
        cmd.b_wr   = 1'b1;
        cmd.finish = stat.idx_last && stat.lvl_top;
      end
      wac_pkg::ST_Q_LOAD: cmd.q_load = 1'b1;
      wac_pkg::ST_Q_UP:   cmd.q_up   = 1'b1;
      wac_pkg::ST_Q_CMP: begin
        cmd.q_cmp  = 1'b1;
        cmd.finish = stat.lvl_zero;
      end
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hw/rtl/wac_dpath.sv
// Datapath: request register, jump and distance tables, counters and climb arithmetic.
module wac_dpath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wac_pkg::wac_req_t                 in_req,
  input  logic                              cfg_we,
  input  logic [wac_pkg::CNT_CFG_W-1:0]     cfg_data,
  input  wac_pkg::wac_cmd_t                 cmd,
  output wac_pkg::wac_stat_t                stat,
  output logic                              out_valid,
  output wac_pkg::wac_rsp_t                 out_rsp
);

  wac_pkg::wac_req_t                   req_r, req_nxt;
  logic [wac_pkg::CNT_CFG_W-1:0]       node_count_r, node_count_nxt;
  logic [wac_pkg::LVL_W-1:0]           lvl_r, lvl_nxt;
  logic [wac_pkg::IDX_W-1:0]           idx_r, idx_nxt;
  logic [wac_pkg::CNT_W-1:0]           n_r, n_nxt;
  logic [wac_pkg::IDX_W-1:0]           cur_r, cur_nxt;
  logic [wac_pkg::IDX_W-1:0]           up_r, up_nxt;
  logic [wac_pkg::DIST_W-1:0]          cur_dist_r, cur_dist_nxt;
  logic signed [wac_pkg::LEFT_W-1:0]   left_r, left_nxt;
  logic                                out_valid_r, out_valid_nxt;
  wac_pkg::wac_rsp_t                   out_rsp_r, out_rsp_nxt;

  logic                                jt_we;
  logic [wac_pkg::JT_AW-1:0]           jt_waddr;
  logic [wac_pkg::IDX_W-1:0]           jt_wdata;
  logic [wac_pkg::JT_AW-1:0]           jt_raddr;
  logic [wac_pkg::IDX_W-1:0]           jt_rdata;
  logic                                dt_we;
  logic [wac_pkg::IDX_W-1:0]           dt_waddr;
  logic [wac_pkg::DIST_W-1:0]          dt_wdata;
  logic [wac_pkg::IDX_W-1:0]           dt_raddr;
  logic [wac_pkg::DIST_W-1:0]          dt_rdata;

  logic                                node_oor;
  logic [wac_pkg::IDX_W-1:0]           node_idx;
  logic [wac_pkg::IDX_W-1:0]           parent_idx;
  logic [wac_pkg::IDX_W-1:0]           jt_clamped;
  logic [wac_pkg::LVL_W-1:0]           lvl_m1;
  logic signed [wac_pkg::COST_W-1:0]   cost;
  logic signed [wac_pkg::LEFT_W-1:0]   cost_ext;
  logic                                take;
  logic [wac_pkg::IDX_W-1:0]           cur_step;

  wac_ram #(.WIDTH(wac_pkg::IDX_W), .DEPTH(wac_pkg::JT_DEPTH)) u_jump_ram (
    .clk   (clk),
    .we    (jt_we),
    .waddr (jt_waddr),
    .wdata (jt_wdata),
    .raddr (jt_raddr),
    .rdata (jt_rdata)
  );

  wac_ram #(.WIDTH(wac_pkg::DIST_W), .DEPTH(wac_pkg::DT_DEPTH)) u_dist_ram (
    .clk   (clk),
    .we    (dt_we),
    .waddr (dt_waddr),
    .wdata (dt_wdata),
    .raddr (dt_raddr),
    .rdata (dt_rdata)
  );

  always_comb begin
    node_oor   = 32'(req_r.node_id) >= 32'(wac_pkg::MAX_NODES);
    node_idx   = wac_pkg::IDX_W'(req_r.node_id);
    parent_idx = (32'(req_r.parent_id) >= 32'(wac_pkg::MAX_NODES)) ?
                 '0 : wac_pkg::IDX_W'(req_r.parent_id);
    jt_clamped = wac_pkg::clamp_idx(jt_rdata);
    lvl_m1     = lvl_r - wac_pkg::LVL_W'(1);

    cost     = $signed({1'b0, cur_dist_r}) - $signed({1'b0, dt_rdata});
    cost_ext = {{(wac_pkg::LEFT_W - wac_pkg::COST_W){cost[wac_pkg::COST_W-1]}}, cost};
    take     = cost_ext <= left_r;
    cur_step = take ? up_r : cur_r;

    stat.op       = req_r.opcode;
    stat.node_oor = node_oor;
    stat.b_skip   = (node_count_r == '0) || (wac_pkg::LEVELS == 1);
    stat.idx_last = (wac_pkg::CNT_W'(idx_r) + wac_pkg::CNT_W'(1)) == n_r;
    stat.lvl_top  = lvl_r == wac_pkg::LVL_W'(wac_pkg::LEVELS - 1);
    stat.lvl_zero = lvl_r == '0;
  end

  always_comb begin
    jt_we    = (cmd.ld_write && !node_oor) || cmd.b_wr;
    jt_waddr = cmd.ld_write ? wac_pkg::JT_AW'({wac_pkg::LVL_W'(0), node_idx}) :
               wac_pkg::JT_AW'({lvl_r, idx_r});
    jt_wdata = cmd.ld_write ? parent_idx : jt_rdata;
    priority if (cmd.q_load) begin
      jt_raddr = wac_pkg::JT_AW'({lvl_r, cur_r});
    end else if (cmd.q_cmp) begin
      jt_raddr = wac_pkg::JT_AW'({lvl_m1, cur_step});
    end else if (cmd.b_rd_a) begin
      jt_raddr = wac_pkg::JT_AW'({lvl_m1, idx_r});
    end else if (cmd.b_rd_b) begin
      jt_raddr = wac_pkg::JT_AW'({lvl_m1, jt_clamped});
    end else begin
      jt_raddr = '0;
    end

    dt_we    = cmd.ld_write && !node_oor;
    dt_waddr = node_idx;
    dt_wdata = req_r.root_distance;
    priority if (cmd.q_init) begin
      dt_raddr = node_idx;
    end else if (cmd.q_up) begin
      dt_raddr = jt_clamped;
    end else begin
      dt_raddr = '0;
    end
  end

  always_comb begin
    req_nxt        = cmd.latch ? in_req : req_r;
    node_count_nxt = cfg_we ? cfg_data : node_count_r;
    lvl_nxt        = lvl_r;
    idx_nxt        = idx_r;
    n_nxt          = n_r;
    cur_nxt        = cur_r;
    up_nxt         = up_r;
    cur_dist_nxt   = cur_dist_r;
    left_nxt       = left_r;

    if (cmd.b_init) begin
      lvl_nxt = wac_pkg::LVL_W'(1);
      idx_nxt = '0;
      n_nxt   = (32'(node_count_r) > 32'(wac_pkg::MAX_NODES)) ?
                wac_pkg::CNT_W'(wac_pkg::MAX_NODES) : wac_pkg::CNT_W'(node_count_r);
    end
    if (cmd.b_wr) begin
      if (stat.idx_last) begin
        idx_nxt = '0;
        lvl_nxt = lvl_r + wac_pkg::LVL_W'(1);
      end else begin
        idx_nxt = idx_r + wac_pkg::IDX_W'(1);
      end
    end
    if (cmd.q_init) begin
      lvl_nxt  = wac_pkg::LVL_W'(wac_pkg::LEVELS - 1);
      cur_nxt  = node_idx;
      left_nxt = $signed({{(wac_pkg::LEFT_W - wac_pkg::BUDG_W){1'b0}}, req_r.budget});
    end
    if (cmd.q_load) begin
      cur_dist_nxt = dt_rdata;
    end
    if (cmd.q_up) begin
      up_nxt = jt_clamped;
    end
    if (cmd.q_cmp) begin
      cur_nxt = cur_step;
      lvl_nxt = lvl_m1;
      if (take) begin
        left_nxt     = left_r - cost_ext;
        cur_dist_nxt = dt_rdata;
      end
    end

    out_valid_nxt = cmd.finish;
    out_rsp_nxt   = out_rsp_r;
    if (cmd.finish) begin
      out_rsp_nxt.done_kind   = req_r.opcode;
      out_rsp_nxt.ancestor_id = (req_r.opcode == wac_pkg::OP_QUERY && !node_oor) ?
                                wac_pkg::NODE_W'(cur_nxt) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      node_count_r <= wac_pkg::NODE_COUNT_RST;
    end else begin
      out_valid_r  <= out_valid_nxt;
      node_count_r <= node_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    lvl_r      <= lvl_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    cur_r      <= cur_nxt;
    up_r       <= up_nxt;
    cur_dist_r <= cur_dist_nxt;
    left_r     <= left_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

FILE: hw/rtl/weighted_ancestor_climb.sv
// Top level: binary lifting level ancestor climb with weighted budget.
// Load writes both tables at dispatch; a build steps levels 1..LEVELS-1 over nodes
// 0..min(node_count, MAX_NODES)-1 unless node_count is 0; one request at a time.
// Each query level reads the jump table, then the distance table.
// The result strobe lasts one cycle and the receiver cannot stall; busy drops with it.
// Synchronous reset clears the controller, the strobe and node_count (1024); tables
// hold no defined contents until loaded and built.
module weighted_ancestor_climb (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  wac_pkg::wac_req_t             in_req,
  output logic                          out_valid,
  output wac_pkg::wac_rsp_t             out_rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wac_pkg::CNT_CFG_W-1:0] cfg_data
);

  wac_pkg::wac_cmd_t  cmd;
  wac_pkg::wac_stat_t stat;

  assign cfg_ready = 1'b1;

  wac_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  wac_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule

FILE: bench/tb_weighted_ancestor_climb.sv
// Self-checking testbench for weighted_ancestor_climb: loads, builds and budgeted climbs.
module tb_weighted_ancestor_climb;
  timeunit 1ns;
  timeprecision 1ps;

  import wac_pkg::*;

  localparam int RESET_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 200000;
  localparam int DRAIN_CYCLES   = 30;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 start     = 1'b0;
  logic                 busy;
  wac_req_t             in_req    = '0;
  logic                 out_valid;
  wac_rsp_t             out_rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CNT_CFG_W-1:0] cfg_data  = '0;

  logic [NODE_W-1:0]    lift_mem [LEVELS][MAX_NODES];
  logic [DIST_W-1:0]    dist_mem [MAX_NODES];
  logic [CNT_CFG_W-1:0] node_limit = NODE_COUNT_RST;
  wac_rsp_t             pending_rsp [$];

  int sender_idle_pct = 0;
  int stall_cycles    = 0;
  int n_fail          = 0;
  int n_checked       = 0;
  int n_load          = 0;
  int n_build         = 0;
  int n_query         = 0;
  int n_ignored       = 0;
  int n_cfg           = 0;

  weighted_ancestor_climb dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void rebuild_lifts();
    int n;
    logic [NODE_W-1:0] mid;
    n = (int'(node_limit) > MAX_NODES) ? MAX_NODES : int'(node_limit);
    for (int lv = 1; lv < LEVELS; lv++) begin
      for (int i = 0; i < n; i++) begin
        mid = lift_mem[lv-1][i];
        lift_mem[lv][i] = lift_mem[lv-1][mid];
      end
    end
  endfunction

  function automatic logic [NODE_W-1:0] predict_climb(input logic [NODE_W-1:0] node,
                                                      input logic [BUDG_W-1:0] energy);
    logic [NODE_W-1:0] cur;
    logic [NODE_W-1:0] up;
    longint remain;
    longint cost;
    cur = node;
    remain = longint'({33'd0, energy});
    for (int lv = LEVELS - 1; lv >= 0; lv--) begin
      up = lift_mem[lv][cur];
      cost = longint'({32'd0, dist_mem[cur]}) - longint'({32'd0, dist_mem[up]});
      if (cost <= remain) begin
        remain -= cost;
        cur = up;
      end
    end
    return cur;
  endfunction

  function automatic void apply_request(input wac_req_t r);
    wac_rsp_t rsp;
    rsp.ancestor_id = '0;
    rsp.done_kind   = r.opcode;
    case (r.opcode)
      OP_LOAD: begin
        lift_mem[0][r.node_id] = r.parent_id;
        dist_mem[r.node_id]    = r.root_distance;
        n_load++;
      end
      OP_BUILD: begin
        rebuild_lifts();
        n_build++;
      end
      OP_QUERY: begin
        rsp.ancestor_id = predict_climb(r.node_id, r.budget);
        n_query++;
      end
      OP_NONE: n_ignored++;
      default: ;
    endcase
    if (r.opcode != OP_NONE) pending_rsp = {pending_rsp, rsp};
  endfunction

  function automatic wac_req_t random_req(input logic [OP_W-1:0] op);
    wac_req_t r;
    r.opcode        = op;
    r.node_id       = NODE_W'($urandom);
    r.parent_id     = NODE_W'($urandom);
    r.root_distance = $urandom;
    r.budget        = BUDG_W'($urandom);
    return r;
  endfunction

  function automatic int pick_parent(input int node, input bit wild);
    int lo;
    if (node == 0) begin
      return (wild && $urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_NODES - 1) : 0;
    end
    lo = (node > 8) ? node - 8 : 0;
    case ($urandom_range(0, 19))
      0, 1, 2: return wild ? $urandom_range(0, MAX_NODES - 1) : $urandom_range(0, node - 1);
      3, 4, 5, 6, 7: return $urandom_range(0, node - 1);
      default: return $urandom_range(lo, node - 1);
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_distance(input int parent);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return dist_mem[parent] - $urandom_range(0, 500);
      default: return dist_mem[parent] + $urandom_range(0, 2000);
    endcase
  endfunction

  function automatic logic [BUDG_W-1:0] pick_budget(input int node);
    logic [DIST_W-1:0] span;
    span = dist_mem[node] - dist_mem[0];
    case ($urandom_range(0, 19))
      0, 1: return '0;
      2, 3: return '1;
      4, 5, 6, 7: return BUDG_W'($urandom);
      default: return span[DIST_W-1] ? BUDG_W'($urandom) : BUDG_W'($urandom_range(0, span + 64));
    endcase
  endfunction

  task automatic issue_request(input wac_req_t r);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(0, 99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy !== 1'b0);
    apply_request(r);
  endtask

  task automatic send_load(input int node, input int parent, input logic [DIST_W-1:0] root_dist);
    wac_req_t r;
    r = random_req(OP_LOAD);
    r.node_id       = NODE_W'(node);
    r.parent_id     = NODE_W'(parent);
    r.root_distance = root_dist;
    issue_request(r);
  endtask

  task automatic send_query(input int node, input logic [BUDG_W-1:0] energy);
    wac_req_t r;
    r = random_req(OP_QUERY);
    r.node_id = NODE_W'(node);
    r.budget  = energy;
    issue_request(r);
  endtask

  task automatic send_build();
    issue_request(random_req(OP_BUILD));
  endtask

  task automatic send_ignored();
    issue_request(random_req(OP_NONE));
  endtask

  // drain: no request in flight, then allow for a dropped opcode-3 request
  task automatic settle_idle();
    start <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0 || busy !== 1'b0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_node_count(input int value);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= CNT_CFG_W'(value);
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    node_limit = CNT_CFG_W'(value);
    n_cfg++;
  endtask

  task automatic test_full_tree_default_count();
    int node;
    sender_idle_pct = 32;
    send_load(0, 0, $urandom_range(0, 1000));
    for (int i = 1; i < MAX_NODES; i++) begin
      node = pick_parent(i, 1'b0);
      send_load(i, node, pick_distance(node));
    end
    send_build();
    repeat (24) begin
      node = $urandom_range(0, MAX_NODES - 1);
      send_query(node, pick_budget(node));
    end
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 59;
    set_node_count(4);
    send_load(0, 0, 0);
    send_load(1, 0, 100);
    send_load(2, 1, 250);
    send_load(3, 2, 32'hFFFF_FFFF);
    send_build();
    send_query(3, '0);
    send_query(3, '1);
    send_query(2, 150);
    send_query(2, 149);
    send_query(0, '0);
    send_ignored();
    // distance below the parent's: the jump refunds budget
    send_load(2, 1, 10);
    send_query(2, '0);
    send_load(1023, 1022, 32'h8000_0000);
    send_query(1023, '1);
    send_load(600, 1023, 32'h0000_0001);
    set_node_count(0);
    send_build();
    send_query(3, 100);
    set_node_count(1);
    send_build();
    send_query(1, 1000);
    set_node_count((1 << CNT_CFG_W) - 1);
    send_build();
    send_query(1023, BUDG_W'($urandom));
  endtask

  task automatic test_random_mix(input int idle_pct, input int n_items);
    int sent;
    int cnt;
    int span;
    int node;
    int parent;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        0: cnt = 0;
        1: cnt = 1;
        2: cnt = $urandom_range(100, 300);
        default: cnt = $urandom_range(2, 48);
      endcase
      set_node_count(cnt);
      span = (cnt == 0) ? MAX_NODES : cnt;
      repeat ($urandom_range(1, 8)) begin
        node = $urandom_range(0, span - 1);
        parent = pick_parent(node, 1'b1);
        send_load(node, parent, pick_distance(parent));
        sent++;
      end
      if ($urandom_range(0, 9) == 0) send_ignored();
      if ($urandom_range(0, 9) == 0) begin
        node = $urandom_range(0, span - 1);
        send_query(node, pick_budget(node));
        sent++;
      end
      send_build();
      sent++;
      repeat ($urandom_range(2, 8)) begin
        node = ($urandom_range(0, 6) == 0) ? $urandom_range(0, MAX_NODES - 1)
                                           : $urandom_range(0, span - 1);
        send_query(node, pick_budget(node));
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin : rsp_check
    wac_rsp_t exp_rsp;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected result: ancestor_id %0d done_kind %0d",
               out_rsp.ancestor_id, out_rsp.done_kind);
        n_fail++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        n_checked++;
        if (out_rsp.ancestor_id !== exp_rsp.ancestor_id) begin
          $error("ancestor_id mismatch: expected %0d, actual %0d",
                 exp_rsp.ancestor_id, out_rsp.ancestor_id);
          n_fail++;
        end
        if (out_rsp.done_kind !== exp_rsp.done_kind) begin
          $error("done_kind mismatch: expected %0d, actual %0d",
                 exp_rsp.done_kind, out_rsp.done_kind);
          n_fail++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid && cfg_ready === 1'b1)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("** weighted_ancestor_climb: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int lv = 0; lv < LEVELS; lv++) begin
      for (int i = 0; i < MAX_NODES; i++) lift_mem[lv][i] = '0;
    end
    for (int i = 0; i < MAX_NODES; i++) dist_mem[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_tree_default_count();
    test_directed_cases();
    test_random_mix(0, 25);
    test_random_mix(59, 25);
    test_random_mix(32, 25);

    settle_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d results: %0d loads, %0d builds, %0d climbs; %0d opcode-3 dropped.",
             n_checked, n_load, n_build, n_query, n_ignored);
    $display("Full 1024-node tree built at the reset count, plus %0d node_count writes (0..2047).",
             n_cfg);
    if (n_fail == 0) begin
      $display("** weighted_ancestor_climb: PASSED **");
    end else begin
      $display("** weighted_ancestor_climb: FAILED **");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/wac_pkg.sv
hw/rtl/wac_ram.sv
hw/rtl/wac_ctrl.sv
hw/rtl/wac_dpath.sv
hw/rtl/weighted_ancestor_climb.sv
bench/tb_weighted_ancestor_climb.sv
